// ===== sv/smx_pkg.sv =====
// Package: shared types and constants for the softmax normalize block
package smx_pkg;

    localparam int unsigned CNT_W = 24;
    localparam int unsigned QBITS = 27;   // 26 quotient bits plus one spare
    localparam logic [15:0] BF16_DEFAULT_NAN = 16'hFFC0;

    typedef enum logic [1:0] {
        t_ST_IDLE = 2'd0,
        t_ST_DIV  = 2'd1,
        t_ST_FIN  = 2'd2,
        t_ST_OUT  = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic release_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

// ===== sv/smx_if.sv =====
// Interfaces: request and result channels
interface smx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] exponential_bits;
    logic [31:0] row_sum_bits;
    logic [31:0] segment_base;
    logic [23:0] row_start;
    logic        last_token;
    modport source (output valid, exponential_bits, row_sum_bits, segment_base,
                    row_start, last_token, input ready);
    modport sink (input valid, exponential_bits, row_sum_bits, segment_base,
                  row_start, last_token, output ready);
endinterface

interface smx_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] probability_bf16;
    logic [31:0] store_offset;
    logic        row_done;
    modport source (output valid, probability_bf16, store_offset, row_done, input ready);
    modport sink (input valid, probability_bf16, store_offset, row_done, output ready);
endinterface

// ===== sv/smx_ctrl.sv =====
// Controller: sequences load, divide iterations, rounding and result release
module smx_ctrl
    import smx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            t_ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = t_ST_DIV;
                end
            end
            t_ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_done) n_state = t_ST_FIN;
            end
            t_ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = t_ST_OUT;
            end
            t_ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.release_out = 1'b1;
                    n_state = t_ST_IDLE;
                end
            end
            default: n_state = t_ST_IDLE;
        endcase
    end
endmodule

// ===== sv/smx_dp.sv =====
// Datapath: restoring FP32 divider, FP32 rounding, BF16 rounding, offset and counter
module smx_dp
    import smx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    input  logic [31:0] i_base,
    input  logic [23:0] i_row_start,
    input  logic        i_last,
    output logic [15:0] o_bf16,
    output logic [31:0] o_offset,
    output logic        o_row_done
);
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_offset;
    logic             r_row_done;
    logic [15:0]      r_bf16;
    logic             r_special;
    logic [15:0]      r_special_val;
    logic             r_sign;
    logic signed [10:0] r_exp;
    logic [24:0]      r_rem;
    logic [23:0]      r_dm;
    logic [QBITS-1:0] r_q;
    logic [4:0]       r_iter;

    // operand unpack with normalization of subnormals
    logic [7:0]  ne, de;
    logic [22:0] nf, df;
    logic        n_nan, d_nan, n_inf, d_inf, n_zero, d_zero;
    logic [23:0] nm, dm;
    logic [4:0]  nlz, dlz;
    logic signed [10:0] nexp, dexp;

    function automatic logic [4:0] lz24(input logic [23:0] v);
        logic [4:0] c;
        c = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) c = 5'(23 - i);
        end
        return c;
    endfunction

    always_comb begin
        ne = i_num[30:23]; nf = i_num[22:0];
        de = i_den[30:23]; df = i_den[22:0];
        n_nan  = (ne == 8'hFF) && (nf != 23'd0);
        d_nan  = (de == 8'hFF) && (df != 23'd0);
        n_inf  = (ne == 8'hFF) && (nf == 23'd0);
        d_inf  = (de == 8'hFF) && (df == 23'd0);
        n_zero = (i_num[30:0] == 31'd0);
        d_zero = (i_den[30:0] == 31'd0);
        nm = {(ne != 8'd0), nf};
        dm = {(de != 8'd0), df};
        nlz = lz24(nm);
        dlz = lz24(dm);
        nexp = $signed({3'd0, (ne == 8'd0) ? 8'd1 : ne}) - $signed({6'd0, nlz});
        dexp = $signed({3'd0, (de == 8'd0) ? 8'd1 : de}) - $signed({6'd0, dlz});
    end

    logic [15:0] sp_val;
    logic        sp;
    logic        sgn;
    always_comb begin
        sgn = i_num[31] ^ i_den[31];
        sp = 1'b1;
        sp_val = 16'd0;
        priority if (n_nan) sp_val = i_num[31:16] | 16'h0040;
        else if (d_nan) sp_val = i_den[31:16] | 16'h0040;
        else if ((n_zero && d_zero) || (n_inf && d_inf)) sp_val = BF16_DEFAULT_NAN;
        else if (n_inf || d_zero) sp_val = {sgn, 15'h7F80};
        else if (n_zero || d_inf) sp_val = {sgn, 15'h0000};
        else sp = 1'b0;
    end

    // one quotient bit per step
    logic [24:0] sub;
    logic        ge;
    always_comb begin
        sub = r_rem - {1'b0, r_dm};
        ge  = (r_rem >= {1'b0, r_dm});
    end
    assign o_status.div_done = (r_iter == 5'(QBITS - 1));

    // final rounding: q has leading one at bit 26 or 25
    logic [QBITS-1:0] qn;
    logic signed [10:0] e;
    logic [23:0] mant;
    logic        grd, stk;
    logic [8:0]  shamt;
    logic [50:0] wide;
    logic [24:0] mr;
    logic [31:0] f32;
    logic [31:0] bsum;
    logic        sticky0;
    always_comb begin
        sticky0 = (r_rem != 25'd0);
        if (r_q[QBITS-1]) begin
            qn = r_q;
            e  = r_exp;
        end else begin
            qn = {r_q[QBITS-2:0], 1'b0};
            e  = r_exp - 11'sd1;
        end
        // normal: mantissa qn[26:3]; subnormal shift right by 1-e
        shamt = (e >= 11'sd1) ? 9'd0 : 9'(11'sd1 - e);
        if (shamt > 9'd26) shamt = 9'd26;
        wide = {qn, 24'd0} >> shamt;
        mant = wide[50:27];
        grd  = wide[26];
        stk  = (wide[25:0] != 26'd0) || sticky0 || (r_q[QBITS-1] ? 1'b0 : 1'b0);
        mr   = {1'b0, mant} + {24'd0, grd && (stk || mant[0])};
        f32  = 32'd0;
        if (e >= 11'sd255) begin
            f32 = {r_sign, 8'hFF, 23'd0};
        end else if (shamt != 9'd0) begin
            f32 = {r_sign, 7'd0, mr[23:0]};
        end else if (mr[24]) begin
            if (e + 11'sd1 >= 11'sd255) f32 = {r_sign, 8'hFF, 23'd0};
            else f32 = {r_sign, 8'(e + 11'sd1), 23'd0};
        end else begin
            f32 = {r_sign, e[7:0], mr[22:0]};
        end
        bsum = f32 + 32'h7FFF + {31'd0, f32[16]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_iter <= '0;
        end else begin
            if (i_cmd.load) begin
                r_iter <= '0;
                r_cnt  <= i_last ? '0 : r_cnt + 1'b1;
            end else if (i_cmd.step) begin
                r_iter <= r_iter + 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_offset      <= i_base + {6'd0, ({1'b0, i_row_start} + {1'b0, r_cnt}), 1'b0};
            r_row_done    <= i_last;
            r_special     <= sp;
            r_special_val <= sp_val;
            r_sign        <= sgn;
            r_exp         <= nexp - dexp + 11'sd127;
            r_rem         <= {1'b0, nm << nlz};
            r_dm          <= dm << dlz;
            r_q           <= '0;
        end else if (i_cmd.step) begin
            r_q   <= {r_q[QBITS-2:0], ge};
            r_rem <= (ge ? sub : r_rem) << 1;
        end
        if (i_cmd.finish) begin
            r_bf16 <= r_special ? r_special_val : bsum[31:16];
        end
    end

    assign o_bf16     = r_bf16;
    assign o_offset   = r_offset;
    assign o_row_done = r_row_done;
endmodule

// ===== sv/softmax_normalize_to_bf16.sv =====
// Top level: softmax normalization of one FP32 exponential to BF16
//  channel | dir | payload
//  i_req   | in  | exponential_bits, row_sum_bits, segment_base, row_start, last_token
//  o_res   | out | probability_bf16, store_offset, row_done
// A request passes in order through load, 27 divider steps, rounding and output.
// The restoring divider yields one quotient bit per cycle and sets the rate.
// Reset is synchronous, active low; it clears the token counter and controller.
// A stalled result holds the block; no request is taken until it leaves.
module softmax_normalize_to_bf16
    import smx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    smx_in_if.sink    i_req,
    smx_out_if.source o_res
);
    t_cmd    w_cmd;
    t_status w_status;

    smx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_res.valid),
        .i_out_ready(o_res.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    smx_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_num      (i_req.exponential_bits),
        .i_den      (i_req.row_sum_bits),
        .i_base     (i_req.segment_base),
        .i_row_start(i_req.row_start),
        .i_last     (i_req.last_token),
        .o_bf16     (o_res.probability_bf16),
        .o_offset   (o_res.store_offset),
        .o_row_done (o_res.row_done)
    );
endmodule

// ===== sv/smx_checker.sv =====
// Checker: port-level properties of the softmax normalize block
module smx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_bf16
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("ready while result pending");
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid) else $error("result too early");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_bf16)))
        else $error("result dropped");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> i_in_ready) else $error("not idle after result");
endmodule

bind softmax_normalize_to_bf16 smx_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_bf16     (o_res.probability_bf16)
);

// ===== tb/softmax_normalize_to_bf16_test.sv =====
// Testbench: random and directed requests against a bit-exact FP32 divide and BF16 round predictor
`timescale 1ns / 100ps

module softmax_normalize_to_bf16_test;
    import smx_pkg::*;

    typedef struct {
        logic [31:0] exponential_bits;
        logic [31:0] row_sum_bits;
        logic [31:0] segment_base;
        logic [23:0] row_start;
        logic        last_token;
    } t_request;

    typedef struct {
        logic [15:0] probability_bf16;
        logic [31:0] store_offset;
        logic        row_done;
    } t_probability;

    class prob_scoreboard;
        t_probability pending_probs[$];
        logic [CNT_W-1:0] token_count;
        int errors;
        int checked;

        function void clear();
            pending_probs.delete();
            token_count = '0;
            errors = 0;
            checked = 0;
        endfunction

        static function logic [31:0] fp32_quotient(logic [31:0] a, logic [31:0] b);
            logic sign;
            logic [79:0] num_ext, quo, rem;
            logic [23:0] ma, mb;
            int ea, eb, p, be, shift;
            logic [63:0] m;
            logic rnd, sticky;
            logic [31:0] mag;
            sign = a[31] ^ b[31];
            if (a[30:23] == 8'hFF || b[30:0] == 31'd0) return {sign, 31'h7F800000};
            if (b[30:23] == 8'hFF || a[30:0] == 31'd0) return {sign, 31'd0};
            ma = (a[30:23] == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
            ea = (a[30:23] == 0) ? -126 : int'(a[30:23]) - 127;
            mb = (b[30:23] == 0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
            eb = (b[30:23] == 0) ? -126 : int'(b[30:23]) - 127;
            while (!ma[23]) begin ma = ma << 1; ea--; end
            while (!mb[23]) begin mb = mb << 1; eb--; end
            num_ext = {56'd0, ma} << 50;
            quo = num_ext / {56'd0, mb};
            rem = num_ext % {56'd0, mb};
            p = quo[50] ? 50 : 49;
            be = ea - eb - 50 + p + 127;
            if (be >= 255) return {sign, 31'h7F800000};
            shift = (be >= 1) ? p - 23 : p - 23 + 1 - be;
            if (shift >= 60) begin
                m = 0; rnd = 0; sticky = 1;
            end else begin
                m = 64'(quo >> shift);
                rnd = quo[shift-1];
                sticky = ((quo & ((80'd1 << (shift - 1)) - 1)) != 0) || (rem != 0);
            end
            if (rnd && (sticky || m[0])) m = m + 1;
            mag = (be >= 1) ? (32'(be - 1) << 23) + m[31:0] : m[31:0];
            if (mag > 32'h7F800000) mag = 32'h7F800000;
            return {sign, mag[30:0]};
        endfunction

        static function logic [15:0] bf16_of_division(logic [31:0] a, logic [31:0] b);
            logic [31:0] q;
            if (a[30:23] == 8'hFF && a[22:0] != 0) return a[31:16] | 16'h0040;
            if (b[30:23] == 8'hFF && b[22:0] != 0) return b[31:16] | 16'h0040;
            if ((a[30:0] == 0 && b[30:0] == 0) ||
                (a[30:0] == 31'h7F800000 && b[30:0] == 31'h7F800000))
                return BF16_DEFAULT_NAN;
            q = fp32_quotient(a, b);
            q = q + 32'h7FFF + q[16];
            return q[31:16];
        endfunction

        function void note(t_request r);
            t_probability e;
            logic [31:0] elem;
            e.probability_bf16 = bf16_of_division(r.exponential_bits, r.row_sum_bits);
            elem = {8'd0, r.row_start} + {8'd0, token_count};
            e.store_offset = r.segment_base + (elem << 1);
            e.row_done = r.last_token;
            pending_probs.push_back(e);
            token_count = r.last_token ? '0 : token_count + 1'b1;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on result %0d: %s got %h expected %h", checked, what, got, want);
            errors++;
        endtask

        task check(t_probability got);
            t_probability e;
            if (pending_probs.size() == 0) begin
                report("unexpected result, offset", got.store_offset, 32'd0);
                return;
            end
            e = pending_probs.pop_front();
            if (got.probability_bf16 !== e.probability_bf16)
                report("probability", 32'(got.probability_bf16), 32'(e.probability_bf16));
            if (got.store_offset !== e.store_offset)
                report("offset", got.store_offset, e.store_offset);
            if (got.row_done !== e.row_done)
                report("row_done", 32'(got.row_done), 32'(e.row_done));
            checked++;
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    bit calm = 0;
    int sent = 0;
    prob_scoreboard board = new();

    smx_in_if  req_if();
    smx_out_if res_if();

    softmax_normalize_to_bf16 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        t_probability got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.probability_bf16 = res_if.probability_bf16;
            got.store_offset = res_if.store_offset;
            got.row_done = res_if.row_done;
            board.check(got);
        end
    end

    // result side: stall in bursts, hold ready high once calm
    initial begin
        res_if.ready = 0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                res_if.ready = 0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            res_if.ready = 1;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    end

    task send_request(t_request r);
        if (!calm && $urandom_range(0, 4) == 0) begin
            req_if.valid = 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        req_if.exponential_bits = r.exponential_bits;
        req_if.row_sum_bits = r.row_sum_bits;
        req_if.segment_base = r.segment_base;
        req_if.row_start = r.row_start;
        req_if.last_token = r.last_token;
        req_if.valid = 1;
        do @(posedge i_clk); while (!req_if.ready);
        board.note(r);
        sent++;
        @(negedge i_clk);
    endtask

    task send_pair(logic [31:0] a, logic [31:0] b, logic last);
        t_request r;
        r.exponential_bits = a;
        r.row_sum_bits = b;
        r.segment_base = $urandom;
        r.row_start = 24'($urandom);
        r.last_token = last;
        send_request(r);
    endtask

    function logic [31:0] random_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 11))
            0: f[30:0] = 0;
            1: f[30:0] = 31'h7F800000;
            2: f[30:23] = 8'hFF;
            3: f[30:23] = 0;
            4: f[30:23] = 8'hFE;
            5: f[30:23] = 8'($urandom_range(1, 20));
            default: ;
        endcase
        return f;
    endfunction

    task send_row();
        t_request r;
        logic [31:0] total;
        int len;
        len = $urandom_range(1, 12);
        total = {1'b0, 8'($urandom_range(100, 150)), 23'($urandom)};
        r.segment_base = $urandom;
        r.row_start = 24'($urandom);
        r.row_sum_bits = total;
        for (int k = 0; k < len; k++) begin
            r.exponential_bits = {1'b0, 8'(int'(total[30:23]) - $urandom_range(0, 30)),
                                  23'($urandom)};
            r.last_token = (k == len - 1);
            send_request(r);
        end
    endtask

    initial begin
        t_request r;
        board.clear();
        req_if.valid = 0;
        req_if.exponential_bits = 0;
        req_if.row_sum_bits = 0;
        req_if.segment_base = 0;
        req_if.row_start = 0;
        req_if.last_token = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_pair(32'h7FC12345, 32'h3F800000, 0);
        send_pair(32'hFF800001, 32'h7FC00000, 0);
        send_pair(32'h3F800000, 32'hFFA5A5A5, 0);
        send_pair(32'h00000000, 32'h80000000, 0);
        send_pair(32'hFF800000, 32'h7F800000, 0);
        send_pair(32'h40000000, 32'h80000000, 0);
        send_pair(32'h7F800000, 32'h3F800000, 0);
        send_pair(32'h3F800000, 32'hFF800000, 0);
        send_pair(32'h7F7FFFFF, 32'h00000001, 0);
        send_pair(32'h00000001, 32'h7F7FFFFF, 0);
        send_pair(32'h00800000, 32'h40000000, 0);
        send_pair(32'h00000003, 32'h40000000, 0);
        send_pair(32'h007FFFFF, 32'h00000001, 0);
        send_pair(32'h3F808000, 32'h3F800000, 0);
        send_pair(32'h3F818000, 32'h3F800000, 0);
        send_pair(32'h3F800000, 32'h40400000, 0);
        send_pair(32'hBF800000, 32'h3F800000, 1);
        r.exponential_bits = 32'h3F000000;
        r.row_sum_bits = 32'h3F800000;
        r.segment_base = 32'hFFFFFFFF;
        r.row_start = 24'hFFFFFF;
        r.last_token = 0;
        send_request(r);
        r.segment_base = 0;
        r.row_start = 0;
        r.last_token = 1;
        send_request(r);

        // hold off until the block drains
        req_if.valid = 0;
        while (board.pending_probs.size() != 0) @(negedge i_clk);

        while (sent < 1900) begin
            if (sent > 1700) calm = 1;
            case ($urandom_range(0, 9))
                0, 1, 2: send_pair(random_float(), random_float(), $urandom_range(0, 3) == 0);
                3: send_pair($urandom, $urandom, 1'($urandom_range(0, 1)));
                default: send_row();
            endcase
        end
        req_if.valid = 0;

        for (int w = 0; w < 100000 && board.pending_probs.size() != 0; w++) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d requests, %0d results checked", sent, board.checked);
        $display("specials, subnormals, rounding ties, offset wrap and row sequences driven");
        if (board.errors == 0 && board.pending_probs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
